FILE: rtl/pmhc_pkg.sv
// Package for the protobuf model header checker.
// Holds the scan state and verdict types, the reason and wire-type codes and the key table.
// No dependencies; pmhc_step and the top level import it.
package pmhc_pkg;

    localparam int unsigned MAX_CONT_BYTES_DEF = 4;
    localparam logic [3:0]  REQUIRED_FIELDS_RST = 4'd3;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    localparam logic [1:0] RSN_OK        = 2'd0;
    localparam logic [1:0] RSN_BAD_KEY   = 2'd1;
    localparam logic [1:0] RSN_REPEAT    = 2'd2;
    localparam logic [1:0] RSN_EARLY_END = 2'd3;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VARINT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] field_seen;
        logic [3:0]  fields_found;
        logic [31:0] varint_accum;
        logic [2:0]  varint_count;
        logic [31:0] skip_remaining;
        logic        is_length;
        logic [3:0]  pending_field;
    } scan_state_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] reason;
    } verdict_t;

    localparam scan_state_t SCAN_CLEAR = '{
        phase:          PH_KEY,
        field_seen:     16'd0,
        fields_found:   4'd0,
        varint_accum:   32'd0,
        varint_count:   3'd0,
        skip_remaining: 32'd0,
        is_length:      1'b0,
        pending_field:  4'd0
    };

    // Fields 1 and 5 carry a varint, 2-4, 6-8 and 14 are length-delimited.
    function automatic logic key_allowed(input logic [3:0] fn, input logic [2:0] wt);
        logic ok;
        case (fn) inside
            4'd1, 4'd5:                                ok = (wt == WT_VARINT);
            4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd14: ok = (wt == WT_LEN);
            default:                                   ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: rtl/pmhc_byte_if.sv
// Byte channel into the header checker: valid/ready plus one stream byte and its end mark.
// Depends on nothing.
interface pmhc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/pmhc_verdict_if.sv
// Verdict channel out of the header checker: valid/ready plus accept flag and reason.
// Depends on nothing.
interface pmhc_verdict_if;
    logic       valid;
    logic       ready;
    logic       verdict_valid;
    logic [1:0] reason;

    modport source (output valid, output verdict_valid, output reason, input ready);
    modport sink   (input valid, input verdict_valid, input reason, output ready);
endinterface

FILE: rtl/protobuf_model_header_checker_unit.sv
// Top level of the protobuf model header checker: scan state, config register, verdict register.
// Depends on pmhc_pkg, pmhc_byte_if, pmhc_verdict_if and pmhc_step.
//
//  channel      dir  handshake      word
//  byte_in      in   valid/ready    data_byte[7:0], last_byte
//  verdict_out  out  valid/ready    verdict_valid, reason[1:0]
//  cfg          in   cfg_we         cfg_wdata[3:0] -> required_fields
//
// One byte per cycle unless stalled; the verdict follows in the cycle after its settling byte.
// The scan state is one register stage, updated by pmhc_step on every accepted byte.
// byte_in stalls only while a verdict sits in the output register and is not taken.
// Reset clears the scan state, empties the output and sets required_fields to 3.
module protobuf_model_header_checker_unit
    import pmhc_pkg::*;
#(
    parameter int unsigned MAX_CONT_BYTES = MAX_CONT_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pmhc_byte_if.sink             byte_in,
    pmhc_verdict_if.source        verdict_out,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_wdata
);

    scan_state_t state_reg;
    scan_state_t state_next;
    verdict_t    verdict;
    logic [3:0]  required_fields_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        verdict_valid_reg;
    logic [1:0]  reason_reg;
    logic        accept_in;

    assign byte_in.ready = !out_valid_reg || verdict_out.ready;
    assign accept_in     = byte_in.valid && byte_in.ready;

    pmhc_step #(
        .MAX_CONT_BYTES (MAX_CONT_BYTES)
    ) u_step (
        .state_cur       (state_reg),
        .data_byte       (byte_in.data_byte),
        .last_byte       (byte_in.last_byte),
        .required_fields (required_fields_reg),
        .state_next      (state_next),
        .verdict         (verdict)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !verdict_out.ready;
        if (accept_in && verdict.hit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= SCAN_CLEAR;
            required_fields_reg <= REQUIRED_FIELDS_RST;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept_in)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                required_fields_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && verdict.hit)
        begin
            verdict_valid_reg <= (verdict.reason == RSN_OK);
            reason_reg        <= verdict.reason;
        end
    end

    assign verdict_out.valid         = out_valid_reg;
    assign verdict_out.verdict_valid = verdict_valid_reg;
    assign verdict_out.reason        = reason_reg;

    // a last byte always leaves a clean scan state behind
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && byte_in.last_byte |=>
            (state_reg.phase == PH_KEY) && (state_reg.fields_found == 4'd0)
            && (state_reg.field_seen == 16'd0))
        else $error("scan state not cleared after last byte");

    // found count tracks the seen mask
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(state_reg.field_seen) == 32'(state_reg.fields_found))
        else $error("fields_found out of step with field_seen");

    // a new verdict only follows an accepted byte
    a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept_in))
        else $error("verdict without accepted byte");

    // accept flag agrees with reason
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_valid_reg == (reason_reg == RSN_OK)))
        else $error("verdict_valid disagrees with reason");

endmodule

FILE: rtl/pmhc_step.sv
// Combinational per-byte step of the field scanner: next scan state and verdict.
// Depends on pmhc_pkg.
module pmhc_step
    import pmhc_pkg::*;
#(
    parameter int unsigned MAX_CONT_BYTES = MAX_CONT_BYTES_DEF
)
(
    input  scan_state_t state_cur,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [3:0]  required_fields,
    output scan_state_t state_next,
    output verdict_t    verdict
);

    logic [3:0]  fn;
    logic [2:0]  wt;
    logic        key_bad;
    logic        cont;
    logic [5:0]  shamt;
    logic [31:0] part_cont;
    logic [31:0] accum_full;
    logic [15:0] field_bit;
    logic        repeat_hit;
    logic [3:0]  found_inc;
    logic        met_now;
    logic        met_before;
    logic [31:0] skip_dec;
    logic        step_hit;
    logic [1:0]  step_reason;

    // decode of the byte against the current state
    always_comb
    begin
        fn         = data_byte[6:3];
        wt         = data_byte[2:0];
        key_bad    = data_byte[7] || !key_allowed(fn, wt);
        cont       = data_byte[7] && (state_cur.varint_count < 3'(MAX_CONT_BYTES));
        shamt      = 6'(state_cur.varint_count) * 6'd7;
        part_cont  = {25'd0, data_byte[6:0]} << shamt;
        // final varint byte goes in with all eight bits
        accum_full = state_cur.varint_accum | ({24'd0, data_byte} << shamt);
        field_bit  = 16'd1 << state_cur.pending_field;
        repeat_hit = |(state_cur.field_seen & field_bit);
        found_inc  = state_cur.fields_found + 4'd1;
        met_now    = (found_inc >= required_fields);
        met_before = (state_cur.fields_found >= required_fields);
        skip_dec   = state_cur.skip_remaining - 32'd1;
    end

    // verdict
    always_comb
    begin
        step_hit    = 1'b0;
        step_reason = RSN_OK;
        if (met_before)
        begin
            step_hit = 1'b1;
        end
        else
        begin
            unique case (state_cur.phase)
                PH_KEY:
                begin
                    if (key_bad)
                    begin
                        step_hit    = 1'b1;
                        step_reason = RSN_BAD_KEY;
                    end
                end
                PH_VARINT:
                begin
                    if (!cont)
                    begin
                        if (repeat_hit)
                        begin
                            step_hit    = 1'b1;
                            step_reason = RSN_REPEAT;
                        end
                        else if (met_now)
                        begin
                            step_hit = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        verdict = '0;
        if (state_cur.phase != PH_DONE)
        begin
            if (step_hit)
            begin
                verdict.hit    = 1'b1;
                verdict.reason = step_reason;
            end
            else if (last_byte)
            begin
                verdict.hit    = 1'b1;
                verdict.reason = RSN_EARLY_END;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_cur;
        if (!met_before)
        begin
            unique case (state_cur.phase)
                PH_KEY:
                begin
                    if (!key_bad)
                    begin
                        state_next.pending_field = fn;
                        state_next.is_length     = (wt == WT_LEN);
                        state_next.varint_accum  = 32'd0;
                        state_next.varint_count  = 3'd0;
                        state_next.phase         = PH_VARINT;
                    end
                end
                PH_VARINT:
                begin
                    if (cont)
                    begin
                        state_next.varint_accum = state_cur.varint_accum | part_cont;
                        state_next.varint_count = state_cur.varint_count + 3'd1;
                    end
                    else
                    begin
                        state_next.varint_accum = accum_full;
                        if (!repeat_hit)
                        begin
                            state_next.field_seen   = state_cur.field_seen | field_bit;
                            state_next.fields_found = found_inc;
                            if (state_cur.is_length && (accum_full != 32'd0))
                            begin
                                state_next.skip_remaining = accum_full;
                                state_next.phase          = PH_SKIP;
                            end
                            else
                            begin
                                state_next.phase = PH_KEY;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    state_next.skip_remaining = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        state_next.phase = PH_KEY;
                    end
                end
                default: ;
            endcase
        end
        if (verdict.hit)
        begin
            state_next.phase = PH_DONE;
        end
        if (last_byte)
        begin
            state_next = SCAN_CLEAR;
        end
    end

endmodule
